FILE: sv/bloom_filter_lcg_probe_assert.svh
// Assertion macros shared by the bloom filter RTL.
`ifndef BLOOM_FILTER_LCG_PROBE_ASSERT_SVH
`define BLOOM_FILTER_LCG_PROBE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFL_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFL_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bfl_pkg.sv
// Shared types and constants of the bloom filter block.
`default_nettype none
package bfl_pkg;

   localparam int unsigned MUL_W   = 24;
   localparam int unsigned X_W     = 48;
   localparam int unsigned PROD_W  = 61;
   localparam int unsigned RANGE_W = 13;
   localparam int unsigned COUNT_W = 7;

   // The 35-bit LCG multiplier split into a low and a high operand.
   localparam logic [MUL_W-1:0] LCG_MUL_LO = 24'hECE66D;
   localparam logic [MUL_W-1:0] LCG_MUL_HI = 24'h0005DE;
   localparam logic [3:0]       LCG_INC    = 4'hB;
   localparam logic [15:0]      LCG_LOW    = 16'h330E;

   localparam logic CSR_INDEX_RANGE = 1'b0;
   localparam logic CSR_PROBE_COUNT = 1'b1;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 13'd4096;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;

   typedef struct packed {
      logic             en;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

endpackage
`default_nettype wire

FILE: sv/bfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfl_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: sv/bfl_mul.sv
// Shared 24 x 24 multiplier with a registered product.
`default_nettype none
module bfl_mul (
   input  wire logic                      clock,
   input  wire bfl_pkg::mul_req_type      req,
   output logic [2*bfl_pkg::MUL_W-1:0]    product
);

   logic [2*bfl_pkg::MUL_W-1:0] p_ff;
   logic [2*bfl_pkg::MUL_W-1:0] p_in;

   assign p_in = req.a * req.b;

   always_ff @(posedge clock) begin
      if (req.en) begin
         p_ff <= p_in;
      end
   end

   assign product = p_ff;

endmodule
`default_nettype wire

FILE: sv/bloom_filter_lcg_probe.sv
// Top level of the bloom filter with LCG-generated probe indexes.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_action, req_data_byte, req_last
//   rsp      out        rsp_valid/rsp_ready    rsp_member
//   csr      in         csr_we                 csr_index, csr_wdata
//
// A key byte that is not last is folded in while idle, and such bytes may arrive every cycle.
// A last byte starts the probes, or goes straight to completion when probe_count is zero. The
// multiplier is shared: each probe issues five products in states ST_M0 to ST_M6, and the wrap,
// needed when MAX_BITS < 8192, adds two products in ST_W0 to ST_W2 before the access in ST_ACC.
// After reset all MAX_BITS bits of the store are cleared one bit per cycle, with no request taken.
// A finished test result waits in an output register; a stalled response only holds
// the block once a following test is ready to report.
`default_nettype none
module bloom_filter_lcg_probe #(
   parameter int unsigned MAX_BITS = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_action,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_member,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [bfl_pkg::RANGE_W-1:0]   csr_wdata
);

   `include "bloom_filter_lcg_probe_assert.svh"

   localparam int unsigned     AW        = $clog2(MAX_BITS);
   localparam int unsigned     MUL_W     = bfl_pkg::MUL_W;
   localparam int unsigned     X_W       = bfl_pkg::X_W;
   localparam int unsigned     PROD_W    = bfl_pkg::PROD_W;
   localparam int unsigned     RANGE_W   = bfl_pkg::RANGE_W;
   localparam int unsigned     COUNT_W   = bfl_pkg::COUNT_W;
   localparam bit              NEED_WRAP = (MAX_BITS < (1 << RANGE_W));
   localparam int unsigned     SH        = RANGE_W + $clog2(MAX_BITS);
   localparam longint unsigned RECIP     = (64'd1 << SH) / MAX_BITS;

   typedef enum logic [13:0] {
      ST_CLEAR = 14'b00000000000001,
      ST_IDLE  = 14'b00000000000010,
      ST_M0    = 14'b00000000000100,
      ST_M1    = 14'b00000000001000,
      ST_M2    = 14'b00000000010000,
      ST_M3    = 14'b00000000100000,
      ST_M4    = 14'b00000001000000,
      ST_M5    = 14'b00000010000000,
      ST_M6    = 14'b00000100000000,
      ST_W0    = 14'b00001000000000,
      ST_W1    = 14'b00010000000000,
      ST_W2    = 14'b00100000000000,
      ST_ACC   = 14'b01000000000000,
      ST_DONE  = 14'b10000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [RANGE_W-1:0]   range_ff, range_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [31:0]          fold_ff, fold_in;
   logic [2:0]           pos_ff, pos_in;
   logic [X_W-1:0]       x_ff, x_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [RANGE_W-1:0]   idx_ff, idx_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [COUNT_W-1:0]   prb_ff, prb_in;
   logic                 action_ff, action_in;
   logic                 all_set_ff, all_set_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 drain_ff, drain_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_member_ff, rsp_member_in;

   logic [31:0]          fold_nx;
   logic [PROD_W-1:0]    shifted_p;
   logic [PROD_W-1:0]    acc_sum;
   logic [RANGE_W-1:0]   sum_idx;
   logic [RANGE_W-1:0]   rem_raw;
   logic [RANGE_W-1:0]   rem_fix;

   bfl_pkg::mul_req_type mul_req;
   logic [2*MUL_W-1:0]   mul_p;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic                 ram_wdata;
   logic                 ram_rdata;

   bfl_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .product (mul_p)
   );

   bfl_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   // Only bytes whose 3-bit wrapping position is below four are folded in.
   assign fold_nx   = pos_ff[2] ? fold_ff
                    : (fold_ff ^ (32'(req_data_byte) << {pos_ff[1:0], 3'b000}));
   assign shifted_p = PROD_W'(mul_p) << MUL_W;
   assign acc_sum   = acc_ff + shifted_p;
   assign sum_idx   = acc_sum[PROD_W-1 -: RANGE_W];
   // The reciprocal quotient is low by at most one, so one correction suffices.
   assign rem_raw   = idx_ff - mul_p[RANGE_W-1:0];
   assign rem_fix   = (32'(rem_raw) >= MAX_BITS) ? (rem_raw - RANGE_W'(MAX_BITS)) : rem_raw;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_member = rsp_member_ff;

   always_comb begin
      state_in      = state_ff;
      range_in      = range_ff;
      count_in      = count_ff;
      fold_in       = fold_ff;
      pos_in        = pos_ff;
      x_in          = x_ff;
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      addr_in       = addr_ff;
      prb_in        = prb_ff;
      action_in     = action_ff;
      all_set_in    = all_set_ff;
      rd_pend_in    = 1'b0;
      drain_in      = 1'b0;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_member_in = rsp_member_ff;
      mul_req       = '0;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = 1'b1;

      if (rd_pend_ff && !ram_rdata) begin
         all_set_in = 1'b0;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_we) begin
         case (csr_index)
            bfl_pkg::CSR_INDEX_RANGE: range_in = csr_wdata;
            bfl_pkg::CSR_PROBE_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 1'b0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_BITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_last) begin
                  fold_in = fold_nx;
                  pos_in  = pos_ff + 3'd1;
               end else begin
                  fold_in    = '0;
                  pos_in     = '0;
                  x_in       = {fold_nx, bfl_pkg::LCG_LOW};
                  action_in  = req_action;
                  all_set_in = 1'b1;
                  prb_in     = count_ff;
                  state_in   = (count_ff == '0) ? ST_DONE : ST_M0;
               end
            end
         end
         // Next LCG value from three partial products, modulo 2^48.
         ST_M0: begin
            mul_req = '{en: 1'b1, a: x_ff[MUL_W-1:0], b: bfl_pkg::LCG_MUL_LO};
            state_in = ST_M1;
         end
         ST_M1: begin
            acc_in   = PROD_W'(mul_p) + PROD_W'(bfl_pkg::LCG_INC);
            mul_req  = '{en: 1'b1, a: x_ff[MUL_W-1:0], b: bfl_pkg::LCG_MUL_HI};
            state_in = ST_M2;
         end
         ST_M2: begin
            acc_in   = acc_sum;
            mul_req  = '{en: 1'b1, a: x_ff[X_W-1 -: MUL_W], b: bfl_pkg::LCG_MUL_LO};
            state_in = ST_M3;
         end
         ST_M3: begin
            x_in     = acc_sum[X_W-1:0];
            state_in = ST_M4;
         end
         // Probe index is the top bits of the exact product X * index_range.
         ST_M4: begin
            mul_req  = '{en: 1'b1, a: x_ff[MUL_W-1:0], b: MUL_W'(range_ff)};
            state_in = ST_M5;
         end
         ST_M5: begin
            acc_in   = PROD_W'(mul_p);
            mul_req  = '{en: 1'b1, a: x_ff[X_W-1 -: MUL_W], b: MUL_W'(range_ff)};
            state_in = ST_M6;
         end
         ST_M6: begin
            idx_in   = sum_idx;
            addr_in  = AW'(sum_idx);
            state_in = NEED_WRAP ? ST_W0 : ST_ACC;
         end
         ST_W0: begin
            mul_req  = '{en: 1'b1, a: MUL_W'(idx_ff), b: MUL_W'(RECIP)};
            state_in = ST_W1;
         end
         ST_W1: begin
            mul_req  = '{en: 1'b1, a: MUL_W'(mul_p >> SH), b: MUL_W'(MAX_BITS)};
            state_in = ST_W2;
         end
         ST_W2: begin
            addr_in  = AW'(rem_fix);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ram_we     = !action_ff;
            rd_pend_in = action_ff;
            prb_in     = prb_ff - 1'b1;
            if (prb_ff == COUNT_W'(1)) begin
               drain_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_M0;
            end
         end
         ST_DONE: begin
            // Waiting while drain_ff is set lets the last read fold into all_set_ff.
            if (drain_ff) begin
               drain_in = 1'b0;
            end else if (!action_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_member_in = all_set_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         range_ff     <= bfl_pkg::RANGE_RESET;
         count_ff     <= bfl_pkg::COUNT_RESET;
         fold_ff      <= '0;
         pos_ff       <= '0;
         prb_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         drain_ff     <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         range_ff     <= range_in;
         count_ff     <= count_in;
         fold_ff      <= fold_in;
         pos_ff       <= pos_in;
         prb_ff       <= prb_in;
         rd_pend_ff   <= rd_pend_in;
         drain_ff     <= drain_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      acc_ff        <= acc_in;
      idx_ff        <= idx_in;
      addr_ff       <= addr_in;
      action_ff     <= action_in;
      all_set_ff    <= all_set_in;
      rsp_member_ff <= rsp_member_in;
   end

   `BFL_ASSERT_IMP(a_read_only_test, rd_pend_ff, action_ff,
      "bit store read pending during an add")
   `BFL_ASSERT_IMP(a_rsp_from_test, $rose(rsp_valid_ff), action_ff,
      "response raised for an add request")
   `BFL_ASSERT_IMP(a_probe_left, state_ff == ST_M0, prb_ff != '0,
      "probe started with no probes remaining")
   `BFL_ASSERT_NXT(a_last_probe_done, state_ff == ST_ACC && prb_ff == COUNT_W'(1),
      state_ff == ST_DONE && drain_ff, "last probe did not lead to completion")

endmodule
`default_nettype wire
